@@ src/segx_pkg.sv @@
`default_nettype none
package segx_pkg;

  localparam int TOL_W   = 16;
  localparam int PARAM_W = 32;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd7;

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_PARALLEL = 2'd1,
    ST_U_RANGE  = 2'd2,
    ST_V_RANGE  = 2'd3
  } status_t;

endpackage
`default_nettype wire

@@ src/segx_div.sv @@
`default_nettype none
module segx_div
  import segx_pkg::*;
#(
  parameter int NW = 115,
  parameter int DW = 67
) (
  input  wire logic               clk,
  input  wire logic               adv,
  input  wire logic [NW-1:0]      num,
  input  wire logic [DW-1:0]      den,
  input  wire logic               neg,
  output logic signed [PARAM_W-1:0] q_out
);

  localparam int QW = PARAM_W;
  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic [CW-1:0] rem_r [QW+1];
  logic [DW-1:0] d_r   [QW+1];
  logic [QW-1:0] q_r   [QW+1];
  logic          neg_r [QW+1];
  logic          ovf_r [QW+1];

  logic [CW-1:0] rem_nxt [QW];
  logic          bit_nxt [QW];

  logic [QW:0]   qc;
  logic [QW:0]   lim;
  logic [QW:0]   mag;
  logic signed [QW-1:0] q_out_r;

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      bit_nxt[k] = rem_r[k] >= (CW'(d_r[k]) << (QW - 1 - k));
      rem_nxt[k] = bit_nxt[k] ? rem_r[k] - (CW'(d_r[k]) << (QW - 1 - k)) : rem_r[k];
    end
  end

  always_comb begin
    qc  = {1'b0, q_r[QW]} + (QW+1)'(rem_r[QW] != '0);
    lim = neg_r[QW] ? (QW+1)'(1) << (QW - 1) : ((QW+1)'(1) << (QW - 1)) - (QW+1)'(1);
    mag = (ovf_r[QW] || qc > lim) ? lim : qc;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= CW'(num);
      d_r[0]   <= den;
      q_r[0]   <= '0;
      neg_r[0] <= neg;
      ovf_r[0] <= CW'(num) >= (CW'(den) << QW);
      for (int k = 0; k < QW; k++) begin
        rem_r[k+1] <= rem_nxt[k];
        d_r[k+1]   <= d_r[k];
        q_r[k+1]   <= {q_r[k][QW-2:0], bit_nxt[k]};
        neg_r[k+1] <= neg_r[k];
        ovf_r[k+1] <= ovf_r[k];
      end
      q_out_r <= neg_r[QW] ? QW'(-mag) : QW'(mag);
    end
  end

  assign q_out = q_out_r;

endmodule
`default_nettype wire

@@ src/segment_intersection_2d.sv @@
// Throughput: one transaction per cycle when not stalled; each quotient is a
// restoring divider with one stage per quotient bit, two dividers running
// side by side. A stall on the result side freezes the whole pipeline.
// Reset (rst_n low, synchronous) clears all valid bits and sets tolerance to 7.
`default_nettype none
module segment_intersection_2d
  import segx_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [TOL_W-1:0]              cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [COORD_WIDTH-1:0] in_ax_start,
  input  wire logic signed [COORD_WIDTH-1:0] in_ay_start,
  input  wire logic signed [COORD_WIDTH-1:0] in_ax_end,
  input  wire logic signed [COORD_WIDTH-1:0] in_ay_end,
  input  wire logic signed [COORD_WIDTH-1:0] in_bx_start,
  input  wire logic signed [COORD_WIDTH-1:0] in_by_start,
  input  wire logic signed [COORD_WIDTH-1:0] in_bx_end,
  input  wire logic signed [COORD_WIDTH-1:0] in_by_end,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_hit,
  output logic [1:0]                         out_status,
  output logic signed [PARAM_W-1:0]          out_param_a,
  output logic signed [PARAM_W-1:0]          out_param_b
);

  localparam int DIF = COORD_WIDTH + 1;
  localparam int PRD = 2 * COORD_WIDTH + 2;
  localparam int CRS = 2 * COORD_WIDTH + 3;
  localparam int NW  = CRS + FRAC_BITS;
  localparam int DL  = PARAM_W + 2;
  localparam int BW  = PARAM_W + 1;

  logic adv;
  logic [TOL_W-1:0] tol_r;

  logic v1_r, v2_r, v3_r, v4_r;
  logic signed [DIF-1:0] ax_r, ay_r, bx_r, by_r, dx_r, dy_r;
  logic signed [PRD-1:0] p_axby_r, p_aybx_r, p_dxby_r, p_dybx_r, p_dxay_r, p_dyax_r;
  logic signed [CRS-1:0] cz_r, nu_r, nv_r;

  logic [CRS-1:0] cz_mag, nu_mag, nv_mag;
  logic           par_nxt;
  logic [NW-1:0]  nu_sh_r, nv_sh_r;
  logic [CRS-1:0] d_r;
  logic           negu_r, negv_r, par4_r;

  logic vd_r  [DL];
  logic par_r [DL];
  logic signed [PARAM_W-1:0] u_q, v_q;

  logic signed [BW-1:0] lowb, highb, u_x, v_x;
  logic u_bad, v_bad;
  status_t st_nxt;

  logic out_valid_r, out_hit_r;
  status_t out_status_r;
  logic signed [PARAM_W-1:0] out_param_a_r, out_param_b_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  always_comb begin
    cz_mag  = cz_r[CRS-1] ? CRS'(-cz_r) : CRS'(cz_r);
    nu_mag  = nu_r[CRS-1] ? CRS'(-nu_r) : CRS'(nu_r);
    nv_mag  = nv_r[CRS-1] ? CRS'(-nv_r) : CRS'(nv_r);
    par_nxt = (cz_mag == '0) ||
              (CRS'(cz_mag) < (CRS'(tol_r) << FRAC_BITS));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax_r <= DIF'(in_ax_end) - DIF'(in_ax_start);
      ay_r <= DIF'(in_ay_end) - DIF'(in_ay_start);
      bx_r <= DIF'(in_bx_end) - DIF'(in_bx_start);
      by_r <= DIF'(in_by_end) - DIF'(in_by_start);
      dx_r <= DIF'(in_bx_start) - DIF'(in_ax_start);
      dy_r <= DIF'(in_by_start) - DIF'(in_ay_start);

      p_axby_r <= PRD'(ax_r) * PRD'(by_r);
      p_aybx_r <= PRD'(ay_r) * PRD'(bx_r);
      p_dxby_r <= PRD'(dx_r) * PRD'(by_r);
      p_dybx_r <= PRD'(dy_r) * PRD'(bx_r);
      p_dxay_r <= PRD'(dx_r) * PRD'(ay_r);
      p_dyax_r <= PRD'(dy_r) * PRD'(ax_r);

      cz_r <= CRS'(p_axby_r) - CRS'(p_aybx_r);
      nu_r <= CRS'(p_dxby_r) - CRS'(p_dybx_r);
      nv_r <= CRS'(p_dxay_r) - CRS'(p_dyax_r);

      nu_sh_r <= NW'(nu_mag) << FRAC_BITS;
      nv_sh_r <= NW'(nv_mag) << FRAC_BITS;
      d_r     <= cz_mag;
      negu_r  <= nu_r[CRS-1] ^ cz_r[CRS-1];
      negv_r  <= nv_r[CRS-1] ^ cz_r[CRS-1];
      par4_r  <= par_nxt;

      par_r[0] <= par4_r;
      for (int k = 1; k < DL; k++) begin
        par_r[k] <= par_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      for (int k = 0; k < DL; k++) begin
        vd_r[k] <= 1'b0;
      end
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      vd_r[0] <= v4_r;
      for (int k = 1; k < DL; k++) begin
        vd_r[k] <= vd_r[k-1];
      end
    end
  end

  segx_div #(.NW(NW), .DW(CRS)) u_div_u (
    .clk  (clk),
    .adv  (adv),
    .num  (nu_sh_r),
    .den  (d_r),
    .neg  (negu_r),
    .q_out(u_q)
  );

  segx_div #(.NW(NW), .DW(CRS)) u_div_v (
    .clk  (clk),
    .adv  (adv),
    .num  (nv_sh_r),
    .den  (d_r),
    .neg  (negv_r),
    .q_out(v_q)
  );

  always_comb begin
    lowb  = -BW'(tol_r);
    highb = (BW'(1) << FRAC_BITS) + BW'(tol_r);
    u_x   = BW'(u_q);
    v_x   = BW'(v_q);
    u_bad = (u_x < lowb) || (u_x > highb);
    v_bad = (v_x < lowb) || (v_x > highb);
    priority if (par_r[DL-1]) begin
      st_nxt = ST_PARALLEL;
    end else if (u_bad) begin
      st_nxt = ST_U_RANGE;
    end else if (v_bad) begin
      st_nxt = ST_V_RANGE;
    end else begin
      st_nxt = ST_HIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vd_r[DL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_status_r  <= st_nxt;
      out_hit_r     <= (st_nxt == ST_HIT);
      out_param_a_r <= (st_nxt == ST_PARALLEL) ? '0 : u_q;
      out_param_b_r <= (st_nxt == ST_PARALLEL || st_nxt == ST_U_RANGE) ? '0 : v_q;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_hit     = out_hit_r;
  assign out_status  = out_status_r;
  assign out_param_a = out_param_a_r;
  assign out_param_b = out_param_b_r;

endmodule
`default_nettype wire

@@ src/segx_chk.sv @@
`default_nettype none
module segx_chk
  import segx_pkg::*;
(
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_stall,
  input wire logic                      out_valid,
  input wire logic                      out_stall,
  input wire logic                      out_hit,
  input wire logic [1:0]                out_status,
  input wire logic signed [PARAM_W-1:0] out_param_a,
  input wire logic signed [PARAM_W-1:0] out_param_b
);

  a_hit_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hit == (out_status == ST_HIT)))
    else $error("hit disagrees with status");

  a_parallel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_PARALLEL) |-> (out_param_a == '0 && out_param_b == '0))
    else $error("parallel transaction with nonzero parameters");

  a_urange_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_U_RANGE) |-> (out_param_b == '0))
    else $error("u out of range with nonzero param_b");

  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && out_stall) |-> !in_stall)
    else $error("input stalled while output is free");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_param_a) && $stable(out_status)))
    else $error("stalled result changed");

endmodule

bind segment_intersection_2d segx_chk u_segx_chk (.*);
`default_nettype wire

@@ dv/segment_intersection_2d_test.sv @@
`timescale 1ns / 1ps
module segment_intersection_2d_test;
  import segx_pkg::*;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic signed [CW-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
  } seg_pair_t;

  typedef struct {
    logic hit;
    status_t status;
    logic signed [PARAM_W-1:0] pa, pb;
  } isect_t;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [TOL_W-1:0] cfg_wdata = '0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [CW-1:0] in_ax_start = 0, in_ay_start = 0, in_ax_end = 0, in_ay_end = 0;
  logic signed [CW-1:0] in_bx_start = 0, in_by_start = 0, in_bx_end = 0, in_by_end = 0;
  logic out_valid;
  logic out_stall = 1;
  logic out_hit;
  logic [1:0] out_status;
  logic signed [PARAM_W-1:0] out_param_a, out_param_b;

  segment_intersection_2d dut (.*);

  always #4 clk = ~clk;

  seg_pair_t pending_pairs[$];
  isect_t expected_isects[$];
  logic [TOL_W-1:0] tol_q = TOL_RESET;
  int errors = 0;
  int accepted = 0;
  int received = 0;
  int hits_seen = 0, par_seen = 0, urange_seen = 0, vrange_seen = 0;
  int idle_cycles = 0;
  bit idling_on = 1;
  int in_gap = 0, out_gap = 0;

  function automatic logic signed [PARAM_W-1:0] sat_quotient(logic signed [127:0] num,
                                                            logic signed [127:0] den);
    logic neg;
    logic [127:0] n, d, q, r;
    logic [127:0] lim;
    neg = num[127] ^ den[127];
    n = (num[127] ? -num : num) << FB;
    d = den[127] ? -den : den;
    q = n / d;
    r = n % d;
    if (r != 0) q = q + 1;
    lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    if (q > lim) q = lim;
    return neg ? -q[PARAM_W-1:0] : q[PARAM_W-1:0];
  endfunction

  function automatic isect_t predict_isect(seg_pair_t s, logic [TOL_W-1:0] tol);
    isect_t res;
    logic signed [127:0] ax, ay, bx, by, dx, dy, cz, mag, lo_b, hi_b, u, v;
    ax = s.ax1 - s.ax0; ay = s.ay1 - s.ay0;
    bx = s.bx1 - s.bx0; by = s.by1 - s.by0;
    dx = s.bx0 - s.ax0; dy = s.by0 - s.ay0;
    cz = ax * by - ay * bx;
    mag = cz[127] ? -cz : cz;
    lo_b = -$signed({112'd0, tol});
    hi_b = (128'sd1 <<< FB) + $signed({112'd0, tol});
    res.pa = 0;
    res.pb = 0;
    res.status = ST_HIT;
    if (mag < ($signed({112'd0, tol}) <<< FB) || mag == 0) begin
      res.status = ST_PARALLEL;
    end else begin
      res.pa = sat_quotient(dx * by - dy * bx, cz);
      u = res.pa;
      if (u < lo_b || u > hi_b) begin
        res.status = ST_U_RANGE;
      end else begin
        res.pb = sat_quotient(dx * ay - dy * ax, cz);
        v = res.pb;
        if (v < lo_b || v > hi_b) res.status = ST_V_RANGE;
      end
    end
    res.hit = (res.status == ST_HIT);
    return res;
  endfunction

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $signed($urandom_range(0, 8)) <<< FB;
      2: return $signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000;
      3: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
    endcase
  endfunction

  function automatic seg_pair_t crossing_pair();
    seg_pair_t s;
    logic signed [CW-1:0] cx, cy;
    int span;
    span = $urandom_range(0, 3) == 0 ? 32'h3fff_ffff : 32'h00ff_ffff;
    cx = $signed($urandom_range(0, span)) - (span >>> 1);
    cy = $signed($urandom_range(0, span)) - (span >>> 1);
    s.ax0 = cx - $signed($urandom_range(0, 32'h00ff_ffff));
    s.ay0 = cy - $signed($urandom_range(0, 32'h00ff_ffff));
    s.ax1 = cx + $signed($urandom_range(0, 32'h00ff_ffff));
    s.ay1 = cy + $signed($urandom_range(0, 32'h00ff_ffff));
    s.bx0 = cx + $signed($urandom_range(0, 32'h00ff_ffff));
    s.by0 = cy - $signed($urandom_range(0, 32'h00ff_ffff));
    s.bx1 = cx - $signed($urandom_range(0, 32'h00ff_ffff));
    s.by1 = cy + $signed($urandom_range(0, 32'h00ff_ffff));
    if ($urandom_range(0, 3) == 0) s.bx1 = s.bx1 + $signed($urandom_range(0, 32'h0fff_ffff));
    return s;
  endfunction

  function automatic seg_pair_t random_pair();
    seg_pair_t s;
    case ($urandom_range(0, 9))
      0, 1: begin
        s.ax0 = rand_coord(); s.ay0 = rand_coord(); s.ax1 = rand_coord();
        s.ay1 = rand_coord(); s.bx0 = rand_coord(); s.by0 = rand_coord();
        s.bx1 = rand_coord(); s.by1 = rand_coord();
      end
      2: begin
        s = crossing_pair();
        s.bx1 = s.bx0 + (s.ax1 - s.ax0) + $signed($urandom_range(0, 3)) - 1;
        s.by1 = s.by0 + (s.ay1 - s.ay0);
      end
      default: s = crossing_pair();
    endcase
    return s;
  endfunction

  function automatic seg_pair_t mk(int a0, int a1, int a2, int a3,
                                   int b0, int b1, int b2, int b3);
    seg_pair_t s;
    s.ax0 = a0; s.ay0 = a1; s.ax1 = a2; s.ay1 = a3;
    s.bx0 = b0; s.by0 = b1; s.bx1 = b2; s.by1 = b3;
    return s;
  endfunction

  task automatic drain_and_write_tol(logic [TOL_W-1:0] value);
    while (pending_pairs.size() != 0 || expected_isects.size() != 0) @(posedge clk);
    repeat (PARAM_W + 12) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 0;
    tol_q = value;
  endtask

  task automatic queue_directed();
    localparam int ONE = 1 << FB;
    pending_pairs.push_back(mk(0, 0, 2*ONE, 2*ONE, 0, 2*ONE, 2*ONE, 0));
    pending_pairs.push_back(mk(0, 0, ONE, 0, 0, ONE, ONE, ONE));
    pending_pairs.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(mk(0, 0, ONE, 0, 3*ONE, -ONE, 3*ONE, ONE));
    pending_pairs.push_back(mk(0, 0, ONE, 0, ONE/2, ONE, ONE/2, 3*ONE));
    pending_pairs.push_back(mk(0, 0, ONE, 0, ONE, -ONE, ONE, ONE));
    pending_pairs.push_back(mk(0, 0, ONE, 0, 0, -ONE, 0, ONE));
    pending_pairs.push_back(mk(0, 0, ONE, 0, ONE + 3, -ONE, ONE + 3, ONE));
    pending_pairs.push_back(mk(0, 0, ONE, 0, -9, -ONE, -9, ONE));
    pending_pairs.push_back(mk(0, 0, 3, 0, 0, 0, 0, 2));
    pending_pairs.push_back(mk(0, 0, 1, 0, 32'h7fff_ffff, -1, 32'h7fff_ffff, 1));
    pending_pairs.push_back(mk(0, 0, 1, 0, 32'h8000_0000, -1, 32'h8000_0000, 1));
    pending_pairs.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                               32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000));
    pending_pairs.push_back(mk(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                               -1, -1, -1, -1));
    pending_pairs.push_back(mk(-1, -1, -1, -1, -1, -1, -1, -1));
    pending_pairs.push_back(mk(0, 0, ONE, ONE, 2*ONE, 2*ONE, 3*ONE, 3*ONE));
  endtask

  initial begin
    logic [TOL_W-1:0] tol_set[5];
    tol_set = '{16'd0, 16'hffff, 16'd1, 16'h0100, 16'd7};
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    queue_directed();
    foreach (tol_set[k]) begin
      drain_and_write_tol(tol_set[k]);
      if (k < 2) queue_directed();
      for (int i = 0; i < 160; i++) pending_pairs.push_back(random_pair());
    end
    while (pending_pairs.size() != 0) @(posedge clk);
    idling_on = 0;
    for (int i = 0; i < 50; i++) pending_pairs.push_back(random_pair());
    while (pending_pairs.size() != 0 || expected_isects.size() != 0) @(posedge clk);
    repeat (PARAM_W + 12) @(posedge clk);
    $display("%0d segment pairs checked: %0d hits, %0d parallel, %0d u out, %0d v out",
             received, hits_seen, par_seen, urange_seen, vrange_seen);
    $display("tolerance swept over 0, 1, 7, 256 and 65535 under random stalls");
    if (errors == 0) begin
      $display("segment_intersection_2d_test: PASS");
    end else begin
      $display("segment_intersection_2d_test: FAIL");
    end
    $finish;
  end

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_isects.push_back(predict_isect(pending_pairs.pop_front(), tol_q));
        accepted++;
      end
      if (in_valid && in_stall) begin
        // hold
      end else if (in_gap > 0) begin
        in_gap--;
        in_valid <= 0;
      end else if (idling_on && $urandom_range(0, 19) == 0) begin
        in_gap = $urandom_range(0, 13);
        in_valid <= 0;
      end else if (pending_pairs.size() > (in_valid && !in_stall ? 0 : 0) &&
                   !cfg_we) begin
        in_valid <= 1;
        in_ax_start <= pending_pairs[0].ax0; in_ay_start <= pending_pairs[0].ay0;
        in_ax_end <= pending_pairs[0].ax1; in_ay_end <= pending_pairs[0].ay1;
        in_bx_start <= pending_pairs[0].bx0; in_by_start <= pending_pairs[0].by0;
        in_bx_end <= pending_pairs[0].bx1; in_by_end <= pending_pairs[0].by1;
      end else begin
        in_valid <= 0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    isect_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        received++;
        if (expected_isects.size() == 0) begin
          $display("%0t: unexpected result status=%0d", $time, out_status);
          errors++;
        end else begin
          e = expected_isects.pop_front();
          case (e.status)
            ST_HIT: hits_seen++;
            ST_PARALLEL: par_seen++;
            ST_U_RANGE: urange_seen++;
            default: vrange_seen++;
          endcase
          if (out_hit !== e.hit || out_status !== e.status ||
              out_param_a !== e.pa || out_param_b !== e.pb) begin
            $display("%0t: mismatch expected hit=%0d status=%0d a=%0d b=%0d,",
                     $time, e.hit, e.status, e.pa, e.pb,
                     " actual hit=%0d status=%0d a=%0d b=%0d",
                     out_hit, out_status, out_param_a, out_param_b);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1;
      end else if (idling_on && $urandom_range(0, 19) == 0) begin
        out_gap = $urandom_range(0, 13);
        out_stall <= 1;
      end else begin
        out_stall <= 0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("segment_intersection_2d_test: FAIL");
        $finish;
      end
    end
  end

endmodule

@@ filelist.f @@
src/segx_pkg.sv
src/segx_div.sv
src/segment_intersection_2d.sv
src/segx_chk.sv
dv/segment_intersection_2d_test.sv
